>>> rtl/core/lfu_cache_lru_tiebreak_assert.svh
// Assertion macros used by the top cache module.
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LFUC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfuc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LFUC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfuc: next-cycle check failed");

`endif

>>> rtl/core/lfuc_pkg.sv
// Types and constants shared by the cache modules.
package lfuc_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] SAT_MAX   = {DATA_W{1'b1}};

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] stamp;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] key;
    } lfuc_entry_t;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] found_data;
        logic [DATA_W-1:0] found_count;
        logic [DATA_W-1:0] victim_key;
    } lfuc_scan_t;

endpackage

>>> rtl/core/lfu_cache_lru_tiebreak.sv
// Fully associative LFU cache with LRU tie break: one result per request. An empty cache
// skips the slot scan; the scan reads one entry per cycle through the single read port.
// Throughput: one request at a time; input ready returns once the result is registered.
// Reset clears occupancy and time counter and sets capacity to 16; slots are not cleared.
module lfu_cache_lru_tiebreak #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,      // capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] value
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] read_value, [63:32] evicted_key
    output logic [1:0]  m_axis_tuser    // [0] hit, [1] evicted
);
    import lfuc_pkg::*;

    `include "lfu_cache_lru_tiebreak_assert.svh"

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(MAX_ENTRIES);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_SHIFT  = 6'b001000,
        ST_INSERT = 6'b010000,
        ST_OUT    = 6'b100000
    } lfuc_state_t;

    lfuc_state_t       state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [OCC_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic [DATA_W-1:0] ts_reg, ts_next;
    logic [DATA_W-1:0] stamp_new;
    logic              op_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] val_reg;
    logic              evict_reg, evict_next;
    logic              res_hit_reg, res_hit_next;
    logic [DATA_W-1:0] res_rv_reg, res_rv_next;
    logic [DATA_W-1:0] res_evk_reg, res_evk_next;
    logic              m_valid_reg, m_valid_next;
    logic [63:0]       m_data_reg;
    logic [1:0]        m_user_reg;
    logic              in_xfer;
    logic              out_load;
    logic              evict_cond;
    logic [DATA_W-1:0] count_inc;
    logic [OCC_W-1:0]  ins_pos;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    lfuc_entry_t       rd_data;
    logic              rd_valid;
    logic [IDX_W-1:0]  rd_addr_q;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    lfuc_entry_t       wr_data;

    lfuc_scan_t        scan_res;
    logic [IDX_W-1:0]  found_idx;
    logic [IDX_W-1:0]  victim_idx;

    lfuc_store #(.DEPTH(MAX_ENTRIES)) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .rd_valid  (rd_valid),
        .rd_addr_q (rd_addr_q),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    lfuc_scan #(.DEPTH(MAX_ENTRIES)) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_xfer),
        .key        (key_reg),
        .in_valid   (rd_valid && (state_reg == ST_SCAN)),
        .in_idx     (rd_addr_q),
        .in_entry   (rd_data),
        .result     (scan_res),
        .found_idx  (found_idx),
        .victim_idx (victim_idx)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    assign stamp_new = (ts_reg == SAT_MAX) ? ts_reg : ts_reg + 1'b1;
    assign count_inc = (scan_res.found_count == SAT_MAX) ? scan_res.found_count
                                                         : scan_res.found_count + 1'b1;

    // Capacity zero acts as one; capacity above the slot count acts as the slot count.
    assign evict_cond = (occ_reg != '0)
                     && ((cap_reg == '0)
                      || (CMP_W'(occ_reg) >= CMP_W'(cap_reg))
                      || (occ_reg == OCC_MAX));

    assign ins_pos = evict_reg ? occ_reg - 1'b1 : occ_reg;

    always_comb
    begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        rd_cnt_next  = rd_cnt_reg;
        ts_next      = ts_reg;
        evict_next   = evict_reg;
        res_hit_next = res_hit_reg;
        res_rv_next  = res_rv_reg;
        res_evk_next = res_evk_reg;
        rd_en        = 1'b0;
        rd_addr      = rd_cnt_reg[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = found_idx;
        wr_data      = rd_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    rd_cnt_next  = '0;
                    evict_next   = 1'b0;
                    res_hit_next = 1'b0;
                    res_rv_next  = '0;
                    res_evk_next = '0;
                    state_next   = (occ_reg == '0) ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // The last read's data is compared in the cycle that leaves this state.
                if (rd_cnt_reg != occ_reg)
                begin
                    rd_en       = 1'b1;
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (scan_res.found)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = found_idx;
                    wr_data.key   = key_reg;
                    wr_data.data  = (op_reg == OP_SET) ? val_reg : scan_res.found_data;
                    wr_data.count = count_inc;
                    wr_data.stamp = stamp_new;
                    ts_next       = stamp_new;
                    res_hit_next  = 1'b1;
                    res_rv_next   = (op_reg == OP_SET) ? '0 : scan_res.found_data;
                    state_next    = ST_OUT;
                end
                else if (op_reg == OP_GET)
                begin
                    state_next = ST_OUT;
                end
                else if (evict_cond)
                begin
                    evict_next   = 1'b1;
                    res_evk_next = scan_res.victim_key;
                    rd_cnt_next  = OCC_W'(victim_idx) + 1'b1;
                    state_next   = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_SHIFT:
            begin
                // Close the gap: slot j+1 is read, then written into slot j in the next cycle.
                if (rd_cnt_reg != occ_reg)
                begin
                    rd_en       = 1'b1;
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
                if (rd_valid)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_addr_q - 1'b1;
                    wr_data = rd_data;
                end
            end
            ST_INSERT:
            begin
                wr_en         = 1'b1;
                wr_addr       = ins_pos[IDX_W-1:0];
                wr_data.key   = key_reg;
                wr_data.data  = val_reg;
                wr_data.count = DATA_W'(1);
                wr_data.stamp = stamp_new;
                ts_next       = stamp_new;
                occ_next      = evict_reg ? occ_reg : occ_reg + 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            occ_reg     <= '0;
            rd_cnt_reg  <= '0;
            ts_reg      <= '0;
            evict_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            rd_cnt_reg  <= rd_cnt_next;
            ts_reg      <= ts_next;
            evict_reg   <= evict_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg  <= s_axis_tuser;
            key_reg <= s_axis_tdata[31:0];
            val_reg <= s_axis_tdata[63:32];
        end
        res_hit_reg <= res_hit_next;
        res_rv_reg  <= res_rv_next;
        res_evk_reg <= res_evk_next;
        if (out_load)
        begin
            m_data_reg <= {res_evk_reg, res_rv_reg};
            m_user_reg <= {evict_reg, res_hit_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `LFUC_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= OCC_MAX)
    `LFUC_ASSERT_NXT(a_busy_after_xfer, clk, rst_n, in_xfer, !s_axis_tready)
    `LFUC_ASSERT_IMP(a_hit_not_evict, clk, rst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
    `LFUC_ASSERT_IMP(a_insert_room, clk, rst_n, (state_reg == ST_INSERT) && !evict_reg, occ_reg < OCC_MAX)

endmodule

>>> rtl/core/lfuc_store.sv
// Slot memory with one write port and one registered read port.
module lfuc_store #(
    parameter int DEPTH = 16,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output lfuc_pkg::lfuc_entry_t rd_data,
    output logic                 rd_valid,
    output logic [IDX_W-1:0]     rd_addr_q,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  lfuc_pkg::lfuc_entry_t wr_data
);
    import lfuc_pkg::*;

    lfuc_entry_t      mem [DEPTH];
    lfuc_entry_t      rd_data_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_data   = rd_data_reg;
    assign rd_addr_q = rd_addr_reg;
    assign rd_valid  = rd_valid_reg;

endmodule

>>> rtl/core/lfuc_scan.sv
// Compare unit that finds the matching key and the eviction victim, one slot per cycle.
module lfuc_scan #(
    parameter int DEPTH = 16,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [lfuc_pkg::DATA_W-1:0] key,
    input  logic                   in_valid,
    input  logic [IDX_W-1:0]       in_idx,
    input  lfuc_pkg::lfuc_entry_t  in_entry,
    output lfuc_pkg::lfuc_scan_t   result,
    output logic [IDX_W-1:0]       found_idx,
    output logic [IDX_W-1:0]       victim_idx
);
    import lfuc_pkg::*;

    logic              found_reg;
    logic [IDX_W-1:0]  found_idx_reg;
    logic [DATA_W-1:0] found_data_reg;
    logic [DATA_W-1:0] found_count_reg;
    logic [IDX_W-1:0]  vic_idx_reg;
    logic [DATA_W-1:0] vic_count_reg;
    logic [DATA_W-1:0] vic_stamp_reg;
    logic [DATA_W-1:0] vic_key_reg;
    logic              is_match;
    logic              is_better;

    assign is_match  = !found_reg && (in_entry.key == key);
    // The first slot seeds the victim; later slots replace it only when strictly better,
    // so among full ties the lowest slot wins.
    assign is_better = (in_idx == '0)
                    || (in_entry.count < vic_count_reg)
                    || ((in_entry.count == vic_count_reg) && (in_entry.stamp < vic_stamp_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (start)
        begin
            found_reg <= 1'b0;
        end
        else if (in_valid && is_match)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && is_match)
        begin
            found_idx_reg   <= in_idx;
            found_data_reg  <= in_entry.data;
            found_count_reg <= in_entry.count;
        end
        if (in_valid && is_better)
        begin
            vic_idx_reg   <= in_idx;
            vic_count_reg <= in_entry.count;
            vic_stamp_reg <= in_entry.stamp;
            vic_key_reg   <= in_entry.key;
        end
    end

    assign result.found       = found_reg;
    assign result.found_data  = found_data_reg;
    assign result.found_count = found_count_reg;
    assign result.victim_key  = vic_key_reg;
    assign found_idx          = found_idx_reg;
    assign victim_idx         = vic_idx_reg;

endmodule

>>> dv/lfu_cache_lru_tiebreak_tb.sv
// Self-checking testbench for the LFU cache with LRU tie break.
module lfu_cache_lru_tiebreak_tb;
    import lfuc_pkg::*;

    localparam int SLOTS        = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 12;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
        logic [DATA_W-1:0] evicted_key;
    } cache_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    lfu_cache_lru_tiebreak #(.MAX_ENTRIES(SLOTS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the cache contents, kept in insertion order.
    logic [DATA_W-1:0] line_key   [SLOTS];
    logic [DATA_W-1:0] line_data  [SLOTS];
    logic [DATA_W-1:0] line_count [SLOTS];
    logic [DATA_W-1:0] line_stamp [SLOTS];
    int unsigned       lines_used;
    logic [DATA_W-1:0] stamp_clock;
    logic [4:0]        capacity_reg;

    cache_result_t pending_results[$];

    int  error_count;
    int  requests_sent;
    int  results_checked;
    int  hits_seen;
    int  evictions_seen;
    bit  no_idle;
    bit  sink_hold_req;

    function automatic logic [DATA_W-1:0] bump_stamp();
        if (stamp_clock != SAT_MAX)
            stamp_clock = stamp_clock + 1;
        return stamp_clock;
    endfunction

    function automatic int unsigned usable_lines();
        int unsigned c;
        c = 32'(capacity_reg);
        if (c == 0)
            c = 1;
        if (c > SLOTS)
            c = SLOTS;
        return c;
    endfunction

    // Applies one request to the shadow cache and returns what the block should report.
    function automatic cache_result_t cache_access(input logic op,
                                                   input logic [DATA_W-1:0] key,
                                                   input logic [DATA_W-1:0] val);
        cache_result_t r;
        int unsigned   n;
        int unsigned   found;
        int unsigned   victim;
        n = lines_used;
        found = n;
        victim = 0;
        r = '0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (found == n && line_key[i] == key)
                found = i;
            if (i > 0 && (line_count[i] < line_count[victim] ||
                          (line_count[i] == line_count[victim] &&
                           line_stamp[i] < line_stamp[victim])))
                victim = i;
        end
        if (found < n)
        begin
            r.hit = 1'b1;
            if (line_count[found] != SAT_MAX)
                line_count[found] = line_count[found] + 1;
            line_stamp[found] = bump_stamp();
            if (op == OP_SET)
                line_data[found] = val;
            else
                r.read_value = line_data[found];
            return r;
        end
        if (op == OP_GET)
            return r;
        if (n > 0 && n >= usable_lines())
        begin
            r.evicted = 1'b1;
            r.evicted_key = line_key[victim];
            for (int unsigned i = victim; i + 1 < n; i++)
            begin
                line_key[i]   = line_key[i + 1];
                line_data[i]  = line_data[i + 1];
                line_count[i] = line_count[i + 1];
                line_stamp[i] = line_stamp[i + 1];
            end
            n--;
        end
        if (n < SLOTS)
        begin
            line_key[n]   = key;
            line_data[n]  = val;
            line_count[n] = 1;
            line_stamp[n] = bump_stamp();
            n++;
        end
        lines_used = n;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        error_count++;
        $display("mismatch at result %0d: %s got %h expected %h",
                 results_checked, what, got, want);
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one request and returns at the falling edge after its transfer.
    task automatic send_request(input logic op, input logic [DATA_W-1:0] key,
                                input logic [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, key};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(cache_access(op, key, val));
        requests_sent++;
        @(negedge clk);
    endtask

    // Stops offering and waits until every outstanding result has been seen.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we    <= 1'b0;
        capacity_reg = cap;
    endtask

    task automatic test_directed_basics();
        write_capacity(5'd16);
        send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(OP_SET, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        // A set that hits updates the value and reports no read data.
        send_request(OP_SET, 32'h0000_0000, 32'h1234_5678);
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_GET, 32'h5A5A_5A5A, 32'h0000_0000);
    endtask

    task automatic test_eviction_rules();
        // Capacity below the current occupancy: each set miss swaps one entry.
        write_capacity(5'd2);
        send_request(OP_SET, 32'h0000_0011, 32'hA5A5_0011);
        send_request(OP_SET, 32'h0000_0022, 32'hA5A5_0022);
        send_request(OP_GET, 32'h0000_0011, 32'h0000_0000);
        // Equal counts fall back to the least recently used entry.
        send_request(OP_SET, 32'h0000_0033, 32'hA5A5_0033);
        send_request(OP_SET, 32'h0000_0044, 32'hA5A5_0044);
        // Capacity zero behaves as a single entry.
        write_capacity(5'd0);
        send_request(OP_SET, 32'h0000_0055, 32'h5555_5555);
        send_request(OP_SET, 32'h0000_0066, 32'h6666_6666);
        send_request(OP_GET, 32'h0000_0066, 32'h0000_0000);
        // Capacity beyond the slot count is clamped to the slot count.
        write_capacity(5'd31);
        send_request(OP_SET, 32'h0000_0077, 32'h7777_7777);
        send_request(OP_SET, 32'h0000_0088, 32'h8888_8888);
        send_request(OP_GET, 32'h0000_0055, 32'h0000_0000);
    endtask

    task automatic test_random_traffic();
        logic [4:0]        phase_cap [8];
        logic [DATA_W-1:0] key_pool [24];
        int                pool_size;
        logic              op;
        logic [DATA_W-1:0] key;
        phase_cap = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd2, 5'd16, 5'd12};
        phase_cap[6] = 5'($urandom_range(1, 16));
        for (int p = 0; p < 8; p++)
        begin
            write_capacity(phase_cap[p]);
            no_idle = (p == 3);
            pool_size = usable_lines() + $urandom_range(1, 6);
            for (int i = 0; i < pool_size; i++)
                key_pool[i] = $urandom();
            for (int i = 0; i < 50; i++)
            begin
                op = ($urandom_range(0, 99) < 55) ? OP_SET : OP_GET;
                if ($urandom_range(0, 99) < 80)
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                else
                    key = $urandom();
                send_request(op, key, $urandom());
            end
            no_idle = 0;
        end
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        sink_hold_req = 1'b1;
        for (int i = 0; i < 16; i++)
            send_request(($urandom_range(0, 1) != 0) ? OP_SET : OP_GET,
                         $urandom_range(0, 7), $urandom());
        wait_idle();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int left;
        bit stall;
        int hold_left;
        int r;
        left = 0;
        stall = 0;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (no_idle)
                m_axis_tready <= 1'b1;
            else
            begin
                if (left == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                    begin
                        stall = 0;
                        left = $urandom_range(1, 20);
                    end
                    else if (r < 90)
                    begin
                        stall = 1;
                        left = $urandom_range(1, 3);
                    end
                    else
                    begin
                        stall = 1;
                        left = $urandom_range(15, 50);
                    end
                end
                m_axis_tready <= !stall;
                left--;
            end
        end
    end

    // Compares every result transfer against the oldest prediction.
    initial
    begin
        cache_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, read_value", m_axis_tdata[31:0], '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser[0] !== want.hit)
                        report_mismatch("hit", DATA_W'(m_axis_tuser[0]), DATA_W'(want.hit));
                    if (m_axis_tdata[31:0] !== want.read_value)
                        report_mismatch("read_value", m_axis_tdata[31:0], want.read_value);
                    if (m_axis_tuser[1] !== want.evicted)
                        report_mismatch("evicted", DATA_W'(m_axis_tuser[1]),
                                        DATA_W'(want.evicted));
                    if (m_axis_tdata[63:32] !== want.evicted_key)
                        report_mismatch("evicted_key", m_axis_tdata[63:32], want.evicted_key);
                    hits_seen += int'(want.hit);
                    evictions_seen += int'(want.evicted);
                end
                results_checked++;
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        no_idle       = 1'b0;
        sink_hold_req = 1'b0;
        error_count     = 0;
        requests_sent   = 0;
        results_checked = 0;
        hits_seen       = 0;
        evictions_seen  = 0;
        lines_used   = 0;
        stamp_clock  = '0;
        capacity_reg = CAP_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_basics();
        test_eviction_rules();
        test_random_traffic();
        test_output_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d requests and %0d results, %0d hits and %0d evictions,",
                 requests_sent, results_checked, hits_seen, evictions_seen);
        $display("over capacities 0 to 31 with random stalls and one long output hold-off");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
